// ===== hdl/follow_target_flight_sequencer_core_macros.svh =====
// Assertion helpers for the sequencer RTL.
`ifndef FOLLOW_TARGET_FLIGHT_SEQUENCER_CORE_MACROS_SVH
`define FOLLOW_TARGET_FLIGHT_SEQUENCER_CORE_MACROS_SVH
// Same-cycle implication, sampled on clk, off while in reset.
`define FTFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftfs assertion failed");
// Next-cycle implication, sampled on clk, off while in reset.
`define FTFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftfs assertion failed");
`endif

// ===== hdl/ftfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ftfs_pkg
// Types, codes and sizes shared by the follow-target flight sequencer.
// -----------------------------------------------------------------------------
package ftfs_pkg;

	localparam int unsigned NUM_REGS   = 8;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned REG_W      = 16;
	localparam int unsigned DELTA_W    = 17;
	localparam int unsigned SUMSQ_W    = 34;
	localparam int unsigned ROOT_W     = 17;
	localparam int unsigned QUOT_W     = 27;
	localparam int unsigned REM_W      = 17;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned SQ_STEPS   = 3;
	localparam int unsigned ROOT_STEPS = 17;
	localparam int unsigned DIV_STEPS  = QUOT_W;
	localparam logic [10:0] TAKEOFF_WAIT_MS = 11'd2000;
	localparam logic [9:0]  MS_PER_S = 10'd1000;

	typedef enum logic [2:0] {
		REG_X_LOW   = 3'd0,
		REG_X_HIGH  = 3'd1,
		REG_Y_LOW   = 3'd2,
		REG_Y_HIGH  = 3'd3,
		REG_SPEED   = 3'd4,
		REG_TMIN    = 3'd5,
		REG_TMAX    = 3'd6,
		REG_HOVER   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ARMED = 2'd1,
		MODE_HOVER = 2'd2,
		MODE_TRACK = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_TRAJ  = 2'd1,
		KIND_POINT = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_ROOT,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [15:0] target_pos_x;
		logic signed [15:0] target_pos_y;
		logic signed [15:0] vehicle_x;
		logic signed [15:0] vehicle_y;
		logic signed [15:0] vehicle_z;
		logic               trajectory_finished;
		logic               tracking_button;
		logic               start_button;
	} tick_t;

	typedef struct packed {
		logic [1:0]         command_kind;
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
		logic signed [15:0] goal_z;
		logic [10:0]        wait_ms;
		logic [15:0]        duration_ms;
		logic               out_of_box;
		logic [1:0]         mode_now;
	} result_t;

	typedef struct packed {
		logic load;
		logic sq_step;
		logic root_step;
		logic mul;
		logic div_step;
		logic dur_done;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic need_travel;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/ftfs_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ftfs tick and result channels
// Valid/ready channels carrying one control tick in and one result out.
// -----------------------------------------------------------------------------
interface ftfs_tick_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target_pos_x;
	logic signed [15:0] target_pos_y;
	logic signed [15:0] vehicle_x;
	logic signed [15:0] vehicle_y;
	logic signed [15:0] vehicle_z;
	logic               trajectory_finished;
	logic               tracking_button;
	logic               start_button;
	modport source (output valid, target_pos_x, target_pos_y, vehicle_x, vehicle_y,
		vehicle_z, trajectory_finished, tracking_button, start_button, input ready);
	modport sink (input valid, target_pos_x, target_pos_y, vehicle_x, vehicle_y,
		vehicle_z, trajectory_finished, tracking_button, start_button, output ready);
endinterface

interface ftfs_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command_kind;
	logic signed [15:0] goal_x;
	logic signed [15:0] goal_y;
	logic signed [15:0] goal_z;
	logic [10:0]        wait_ms;
	logic [15:0]        duration_ms;
	logic               out_of_box;
	logic [1:0]         mode_now;
	modport source (output valid, command_kind, goal_x, goal_y, goal_z, wait_ms,
		duration_ms, out_of_box, mode_now, input ready);
	modport sink (input valid, command_kind, goal_x, goal_y, goal_z, wait_ms,
		duration_ms, out_of_box, mode_now, output ready);
endinterface

`default_nettype wire

// ===== hdl/ftfs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ftfs_ctrl
// Sequences one tick through load, squares, root, scale, divide, clamp and output.
// -----------------------------------------------------------------------------
module ftfs_ctrl
	import ftfs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  tick_valid,
	output logic       tick_ready,
	output logic       res_valid,
	input  wire logic  res_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		tick_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tick_ready = 1'b1;
				if (tick_valid) begin
					cmd.load = 1'b1;
					cnt_d    = CNT_W'(SQ_STEPS - 1);
					state_d  = stat.need_travel ? ST_SQR : ST_DONE;
				end
			end
			ST_SQR: begin
				cmd.sq_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					cnt_d   = CNT_W'(ROOT_STEPS - 1);
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = CNT_W'(DIV_STEPS - 1);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.dur_done = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || res_ready) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/ftfs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ftfs_datapath
// Register file, mode sequencer update and the travel time arithmetic.
// -----------------------------------------------------------------------------
module ftfs_datapath
	import ftfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	input  wire tick_t                tick,
	input  wire cmd_t                 cmd,
	output stat_t                     stat,
	output result_t                   res
);

	logic signed [15:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic [15:0] speed_q, tmin_q, tmax_q;
	logic [14:0] hover_q;

	mode_t mode_q;
	logic airborne_q, follow_q, done_q;

	result_t pend_q, out_q;
	logic [DELTA_W-1:0] ax_q, ay_q, az_q;
	logic [SUMSQ_W-1:0] acc_q, bit_q, root_q;
	logic [REM_W+QUOT_W-1:0] div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= -16'sd1000;
			x_high_q <= 16'sd1000;
			y_low_q  <= -16'sd1500;
			y_high_q <= 16'sd1500;
			speed_q  <= 16'd200;
			tmin_q   <= 16'd1000;
			tmax_q   <= 16'd10000;
			hover_q  <= 15'd1000;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_X_LOW:  x_low_q  <= cfg_data;
				REG_X_HIGH: x_high_q <= cfg_data;
				REG_Y_LOW:  y_low_q  <= cfg_data;
				REG_Y_HIGH: y_high_q <= cfg_data;
				REG_SPEED:  speed_q  <= cfg_data;
				REG_TMIN:   tmin_q   <= cfg_data;
				REG_TMAX:   tmax_q   <= cfg_data;
				REG_HOVER:  hover_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Tick update: events first, then one mode step.
	logic done_ev, air_ev, follow_ev;
	mode_t mode_d;
	logic done_d, need_travel;
	result_t pend_d;
	logic signed [15:0] cx, cy, hov_s;
	logic signed [DELTA_W-1:0] dx, dy, dz;

	function automatic logic signed [15:0] clamp16(logic signed [15:0] v,
		logic signed [15:0] hi, logic signed [15:0] lo);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [DELTA_W-1:0] mag(logic signed [DELTA_W-1:0] v);
		return v[DELTA_W-1] ? DELTA_W'(-v) : v;
	endfunction

	always_comb begin
		done_ev   = done_q | tick.trajectory_finished;
		air_ev    = airborne_q;
		follow_ev = follow_q;
		if (tick.tracking_button && airborne_q)
			follow_ev = !follow_q;
		else if (tick.start_button && mode_q == MODE_IDLE)
			air_ev = 1'b1;
		cx    = clamp16(tick.target_pos_x, x_high_q, x_low_q);
		cy    = clamp16(tick.target_pos_y, y_high_q, y_low_q);
		hov_s = {1'b0, hover_q};
		mode_d = mode_q;
		done_d = done_ev;
		need_travel = 1'b0;
		dx = '0;
		dy = '0;
		dz = '0;
		pend_d = '0;
		pend_d.out_of_box = (tick.vehicle_x > x_high_q) || (tick.vehicle_x < x_low_q) ||
			(tick.vehicle_y > y_high_q) || (tick.vehicle_y < y_low_q);
		case (mode_q)
			MODE_IDLE: begin
				if (air_ev && done_ev)
					mode_d = MODE_ARMED;
			end
			MODE_ARMED: begin
				if (done_ev) begin
					pend_d.command_kind = KIND_TRAJ;
					pend_d.goal_z  = hov_s;
					pend_d.wait_ms = TAKEOFF_WAIT_MS;
					need_travel = 1'b1;
					dx = DELTA_W'(tick.vehicle_x);
					dy = DELTA_W'(tick.vehicle_y);
					dz = DELTA_W'(hov_s) - DELTA_W'(tick.vehicle_z);
					done_d = 1'b0;
					mode_d = MODE_HOVER;
				end
			end
			MODE_HOVER: begin
				if (follow_ev && done_ev) begin
					pend_d.command_kind = KIND_TRAJ;
					pend_d.goal_x = cx;
					pend_d.goal_y = cy;
					pend_d.goal_z = hov_s;
					need_travel = 1'b1;
					dx = DELTA_W'(cx) - DELTA_W'(tick.vehicle_x);
					dy = DELTA_W'(cy) - DELTA_W'(tick.vehicle_y);
					done_d = 1'b0;
					mode_d = MODE_TRACK;
				end
			end
			default: begin
				if (done_ev) begin
					pend_d.command_kind = KIND_POINT;
					pend_d.goal_x = cx;
					pend_d.goal_y = cy;
					pend_d.goal_z = hov_s;
				end
				if (!follow_ev)
					mode_d = MODE_HOVER;
			end
		endcase
		pend_d.mode_now = mode_d;
	end

	assign stat.need_travel = need_travel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			airborne_q <= 1'b0;
			follow_q   <= 1'b0;
			done_q     <= 1'b1;
		end else if (cmd.load) begin
			mode_q     <= mode_d;
			airborne_q <= air_ev;
			follow_q   <= follow_ev;
			done_q     <= done_d;
		end
	end

	// Digit-by-digit square root step and restoring divide step.
	logic [SUMSQ_W:0] trial;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W:0]   rem_diff;
	logic [QUOT_W-1:0] quot;
	logic [SUMSQ_W-1:0] sq;
	logic [QUOT_W-1:0]  scaled;

	assign trial    = {1'b0, root_q} + {1'b0, bit_q};
	assign rem_sh   = {div_q[REM_W+QUOT_W-2:QUOT_W], div_q[QUOT_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b0, speed_q};
	assign quot     = div_q[QUOT_W-1:0];
	assign sq       = {{(SUMSQ_W-DELTA_W){1'b0}}, ax_q} * {{(SUMSQ_W-DELTA_W){1'b0}}, ax_q};
	assign scaled   = {{(QUOT_W-ROOT_W){1'b0}}, root_q[ROOT_W-1:0]} *
		{{(QUOT_W-10){1'b0}}, MS_PER_S};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_q <= pend_d;
			ax_q   <= mag(dx);
			ay_q   <= mag(dy);
			az_q   <= mag(dz);
			acc_q  <= '0;
			root_q <= '0;
			bit_q  <= SUMSQ_W'(1) << 32;
		end
		if (cmd.sq_step) begin
			acc_q <= acc_q + sq;
			ax_q  <= ay_q;
			ay_q  <= az_q;
		end
		if (cmd.root_step) begin
			if ({1'b0, acc_q} >= trial) begin
				acc_q  <= acc_q - trial[SUMSQ_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.mul)
			div_q <= {{REM_W{1'b0}}, scaled};
		if (cmd.div_step) begin
			if (!rem_diff[REM_W])
				div_q <= {rem_diff[REM_W-1:0], quot[QUOT_W-2:0], 1'b1};
			else
				div_q <= {rem_sh, quot[QUOT_W-2:0], 1'b0};
		end
		// A zero speed leaves an all-ones quotient, which clamps to the maximum.
		if (cmd.dur_done) begin
			if (quot > QUOT_W'(tmax_q))
				pend_q.duration_ms <= tmax_q;
			else if (quot < QUOT_W'(tmin_q))
				pend_q.duration_ms <= tmin_q;
			else
				pend_q.duration_ms <= quot[15:0];
		end
		if (cmd.push)
			out_q <= pend_q;
	end

	assign res = out_q;

endmodule

`default_nettype wire

// ===== hdl/follow_target_flight_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// follow_target_flight_sequencer_core
// Takeoff and target-follow command sequencer with iterative travel timing.
// -----------------------------------------------------------------------------
// Takes one control tick at a time and returns exactly one result per tick.
// A tick that issues no trajectory goes from load straight to the output
// register. A trajectory tick runs 3 multiply-accumulate steps for the squared
// distance, 17 square root steps, one scale by 1000, 27 restoring divide steps
// by max_speed and one clamp, then loads the output register. Either path
// waits before that load while a previous result still waits to be taken.
// The next tick is accepted once the result is in the output register, even
// while it still waits to be taken. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module follow_target_flight_sequencer_core
	import ftfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	ftfs_tick_if.sink                 tick,
	ftfs_result_if.source             result
);

`include "follow_target_flight_sequencer_core_macros.svh"

	cmd_t    cmd;
	stat_t   stat;
	tick_t   tick_pl;
	result_t res_pl;

	assign tick_pl.target_pos_x        = tick.target_pos_x;
	assign tick_pl.target_pos_y        = tick.target_pos_y;
	assign tick_pl.vehicle_x           = tick.vehicle_x;
	assign tick_pl.vehicle_y           = tick.vehicle_y;
	assign tick_pl.vehicle_z           = tick.vehicle_z;
	assign tick_pl.trajectory_finished = tick.trajectory_finished;
	assign tick_pl.tracking_button     = tick.tracking_button;
	assign tick_pl.start_button        = tick.start_button;

	ftfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	ftfs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_pl),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res_pl)
	);

	assign result.command_kind = res_pl.command_kind;
	assign result.goal_x       = res_pl.goal_x;
	assign result.goal_y       = res_pl.goal_y;
	assign result.goal_z       = res_pl.goal_z;
	assign result.wait_ms      = res_pl.wait_ms;
	assign result.duration_ms  = res_pl.duration_ms;
	assign result.out_of_box   = res_pl.out_of_box;
	assign result.mode_now     = res_pl.mode_now;

	// An accepted tick keeps the input closed while it is worked on.
	`FTFS_ASSERT_NEXT(a_busy_after_accept, tick.valid && tick.ready, !tick.ready)
	`FTFS_ASSERT_NOW(a_kind_legal, result.valid, result.command_kind != KIND_RSVD)
	// Nothing is commanded in a tick that ends idle or armed.
	`FTFS_ASSERT_NOW(a_idle_quiet,
		result.valid && (result.mode_now == MODE_IDLE || result.mode_now == MODE_ARMED),
		result.command_kind == KIND_NONE)
	// Only a takeoff carries a dwell.
	`FTFS_ASSERT_NOW(a_wait_takeoff, result.valid && result.wait_ms != 11'd0,
		result.command_kind == KIND_TRAJ && result.mode_now == MODE_HOVER)

endmodule

`default_nettype wire

// ===== tb/sv/ftfs_tb_ifs.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ftfs_tb_ifs
// Interfaces used only by the testbench: the configuration write port.
// -----------------------------------------------------------------------------
interface ftfs_cfg_if;
	logic        we;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output we, index, data);
	modport sink (input we, index, data);
endinterface

// ===== tb/sv/ftfs_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ftfs_checker
// Watches the tick and result channels, predicts every result and compares it.
// -----------------------------------------------------------------------------
module ftfs_checker
	import ftfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	ftfs_tick_if.sink   tick,
	ftfs_result_if.sink result,
	output int          fail_count,
	output int          pending,
	output int          trajectories,
	output int          point_goals
);

	logic signed [15:0] box_x_lo, box_x_hi, box_y_lo, box_y_hi;
	logic [15:0]        speed, t_min, t_max;
	logic [14:0]        hover;
	mode_t              seq_mode;
	logic               airborne, follow_on, move_done;
	result_t            expected_results[$];

	function automatic logic [63:0] root_of(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] flight_time(input longint dx, input longint dy,
		input longint dz);
		logic [63:0] d, t;
		d = root_of(dx * dx + dy * dy + dz * dz);
		if (speed == 0) return t_max;
		t = d * 1000 / speed;
		if (t > t_max) return t_max;
		if (t < t_min) return t_min;
		return t[15:0];
	endfunction

	function automatic longint limit(input longint v, input longint hi, input longint lo);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	task automatic predict_tick(input tick_t t);
		result_t r;
		longint  gx, gy;
		r = '0;
		if (t.trajectory_finished) move_done = 1;
		if (t.tracking_button && airborne) follow_on = !follow_on;
		else if (t.start_button && seq_mode == MODE_IDLE) airborne = 1;
		r.out_of_box = (t.vehicle_x > box_x_hi) || (t.vehicle_x < box_x_lo) ||
			(t.vehicle_y > box_y_hi) || (t.vehicle_y < box_y_lo);
		gx = limit(t.target_pos_x, box_x_hi, box_x_lo);
		gy = limit(t.target_pos_y, box_y_hi, box_y_lo);
		case (seq_mode)
			MODE_IDLE: if (airborne && move_done) seq_mode = MODE_ARMED;
			MODE_ARMED: if (move_done) begin
				r.command_kind = KIND_TRAJ;
				r.goal_z = hover;
				r.wait_ms = 11'd2000;
				r.duration_ms = flight_time(t.vehicle_x, t.vehicle_y,
					longint'(hover) - t.vehicle_z);
				move_done = 0;
				seq_mode = MODE_HOVER;
			end
			MODE_HOVER: if (follow_on && move_done) begin
				r.command_kind = KIND_TRAJ;
				r.goal_x = gx;
				r.goal_y = gy;
				r.goal_z = hover;
				r.duration_ms = flight_time(gx - t.vehicle_x, gy - t.vehicle_y, 0);
				move_done = 0;
				seq_mode = MODE_TRACK;
			end
			default: begin
				if (move_done) begin
					r.command_kind = KIND_POINT;
					r.goal_x = gx;
					r.goal_y = gy;
					r.goal_z = hover;
				end
				if (!follow_on) seq_mode = MODE_HOVER;
			end
		endcase
		r.mode_now = seq_mode;
		expected_results = {expected_results, r};
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_lo = -16'sd1000; box_x_hi = 16'sd1000;
			box_y_lo = -16'sd1500; box_y_hi = 16'sd1500;
			speed = 200; t_min = 1000; t_max = 10000; hover = 1000;
			seq_mode = MODE_IDLE; airborne = 0; follow_on = 0; move_done = 1;
			expected_results.delete();
			fail_count = 0; trajectories = 0; point_goals = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_X_LOW:  box_x_lo = cfg_data;
					REG_X_HIGH: box_x_hi = cfg_data;
					REG_Y_LOW:  box_y_lo = cfg_data;
					REG_Y_HIGH: box_y_hi = cfg_data;
					REG_SPEED:  speed = cfg_data;
					REG_TMIN:   t_min = cfg_data;
					REG_TMAX:   t_max = cfg_data;
					default:    hover = cfg_data[14:0];
				endcase
			end
			// Compare first: a result can never belong to a tick taken this same edge.
			if (result.valid && result.ready) begin
				result_t got, exp_r;
				got = '{result.command_kind, result.goal_x, result.goal_y, result.goal_z,
					result.wait_ms, result.duration_ms, result.out_of_box, result.mode_now};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, got);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						$display("%0t: result mismatch expected %p actual %p",
							$time, exp_r, got);
						fail_count++;
					end
					if (exp_r.command_kind == KIND_TRAJ) trajectories++;
					if (exp_r.command_kind == KIND_POINT) point_goals++;
				end
			end
			if (tick.valid && tick.ready)
				predict_tick('{tick.target_pos_x, tick.target_pos_y, tick.vehicle_x,
					tick.vehicle_y, tick.vehicle_z, tick.trajectory_finished,
					tick.tracking_button, tick.start_button});
		end
	end

endmodule

// ===== tb/sv/follow_target_flight_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// follow_target_flight_sequencer_core_tb
// Drives control ticks and register settings into the sequencer and reports
// the verdict from the checker, which predicts and compares every result.
// -----------------------------------------------------------------------------
module follow_target_flight_sequencer_core_tb;
	import ftfs_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count, pending, trajectories, point_goals;
	logic quiet;

	ftfs_cfg_if    cfg ();
	ftfs_tick_if   tick ();
	ftfs_result_if result ();

	follow_target_flight_sequencer_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg.we), .cfg_index(cfg.index),
		.cfg_data(cfg.data), .tick(tick), .result(result)
	);

	ftfs_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg.we), .cfg_index(cfg.index),
		.cfg_data(cfg.data), .tick(tick), .result(result), .fail_count(fail_count),
		.pending(pending), .trajectories(trajectories), .point_goals(point_goals)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// Result side stalls in random bursts until the quiet tail of the run.
	initial begin
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				result.ready <= 0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			result.ready <= 1;
		end
	end

	// One write beat, after which the enable drops before the task returns.
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg.we <= 1;
		cfg.index <= idx;
		cfg.data <= value;
		@(negedge clk);
		cfg.we <= 0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// Valid is low on entry; it drops after the accepting edge, before the task
	// returns.
	task automatic send_tick(input logic signed [15:0] tx, ty, vx, vy, vz,
		input logic fin, tb, sb);
		if (!quiet && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 11)) @(negedge clk);
		tick.valid <= 1;
		tick.target_pos_x <= tx; tick.target_pos_y <= ty;
		tick.vehicle_x <= vx; tick.vehicle_y <= vy; tick.vehicle_z <= vz;
		tick.trajectory_finished <= fin;
		tick.tracking_button <= tb;
		tick.start_button <= sb;
		@(posedge clk);
		while (!tick.ready) @(posedge clk);
		@(negedge clk);
		tick.valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] any16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 4000) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly small coordinates so the tracking path is exercised in range,
	// with full-width values mixed in.
	function automatic logic [15:0] pos16();
		return ($urandom_range(0, 3) == 0) ? any16()
			: 16'($urandom_range(0, 6000) - 3000);
	endfunction

	task automatic random_ticks(input int count);
		int  i;
		for (i = 0; i < count; i++)
			send_tick(pos16(), pos16(), pos16(), pos16(), pos16(),
				$urandom_range(0, 2) != 0, $urandom_range(0, 5) == 0,
				$urandom_range(0, 9) == 0);
	endtask

	task automatic random_config();
		write_reg(REG_X_LOW, 16'($urandom_range(0, 3000) - 3000));
		write_reg(REG_X_HIGH, 16'($urandom_range(0, 3000)));
		write_reg(REG_Y_LOW, 16'($urandom_range(0, 3000) - 3000));
		write_reg(REG_Y_HIGH, 16'($urandom_range(0, 3000)));
		write_reg(REG_SPEED, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 900)));
		write_reg(REG_TMIN, 16'($urandom_range(0, 3000)));
		write_reg(REG_TMAX, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30000)));
		write_reg(REG_HOVER, 16'($urandom_range(0, 32767)));
	endtask

	initial begin
		int phase;
		quiet = 0;
		arst_n = 0;
		cfg.we = 0; cfg.index = REG_X_LOW; cfg.data = 0;
		tick.valid = 0;
		tick.target_pos_x = 0; tick.target_pos_y = 0;
		tick.vehicle_x = 0; tick.vehicle_y = 0; tick.vehicle_z = 0;
		tick.trajectory_finished = 0; tick.tracking_button = 0; tick.start_button = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: tracking button on the ground, start, takeoff, follow, toggle off and on again.
		send_tick(0, 0, 16'sh7fff, -16'sd32768, 0, 0, 1, 0);
		send_tick(0, 0, 0, 0, 0, 0, 0, 1);
		send_tick(0, 0, -16'sd32768, 16'sh7fff, -16'sd32768, 0, 0, 0);
		send_tick(5000, -5000, 1001, -1501, 100, 0, 1, 0);
		send_tick(5000, -5000, 0, 0, 1000, 1, 0, 0);
		send_tick(-16'sd32768, 16'sh7fff, 0, 0, 1000, 1, 0, 0);
		send_tick(300, 400, 0, 0, 1000, 0, 0, 0);
		send_tick(16'sh7fff, -16'sd32768, 0, 0, 1000, 1, 1, 1);
		send_tick(0, 0, 0, 0, 1000, 1, 0, 0);
		send_tick(0, 0, 0, 0, 1000, 1, 1, 0);
		send_tick(200, 100, 1000, 1500, 1000, 1, 0, 0);
		drain_results();

		// Extremes: zero speed, inverted limits and inverted box.
		write_reg(REG_SPEED, 0);
		write_reg(REG_TMIN, 16'hffff);
		write_reg(REG_TMAX, 0);
		write_reg(REG_X_LOW, 16'sh7fff);
		write_reg(REG_X_HIGH, -16'sd32768);
		write_reg(REG_HOVER, 16'h7fff);
		send_tick(100, 100, 0, 0, 0, 1, 1, 0);
		send_tick(100, 100, 0, 0, 0, 1, 0, 0);
		drain_results();
		write_reg(REG_SPEED, 1);
		write_reg(REG_SPEED, 16'hffff);
		write_reg(REG_Y_LOW, -16'sd32768);
		write_reg(REG_Y_HIGH, 16'sh7fff);
		send_tick(-16'sd32768, 16'sh7fff, 16'sh7fff, -16'sd32768, 0, 1, 1, 0);
		send_tick(0, 0, 0, 0, 0, 1, 0, 0);
		drain_results();
		write_reg(REG_SPEED, 1);
		write_reg(REG_TMAX, 16'hffff);
		write_reg(REG_TMIN, 0);
		send_tick(-16'sd32768, 16'sh7fff, 16'sh7fff, -16'sd32768, 0, 1, 1, 0);
		send_tick(16'sh7fff, 16'sh7fff, -16'sd32768, -16'sd32768, 0, 1, 0, 0);
		drain_results();

		for (phase = 0; phase < 6; phase++) begin
			random_config();
			random_ticks(280);
			drain_results();
		end
		quiet = 1;
		random_ticks(60);
		drain_results();

		$display("Run covered %0d trajectory and %0d point-goal results over takeoff,",
			trajectories, point_goals);
		$display("tracking toggles, extreme bounds and speeds, and six random settings.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
